@@ src/aabbc_pkg.sv @@
// shared widths, pair kind codes, pipeline record types and step functions
// for the box/circle narrow-phase collision pipeline
// no dependencies
package aabbc_pkg;

  // field widths
  localparam int KW = 2;
  localparam int CW = 24;
  localparam int HW = 22;
  localparam int NW = 16;
  localparam int PW = 23;
  localparam int MW = 32;
  localparam int LW = 5;

  // internal widths
  localparam int DW    = 25;           // center differences and box bounds
  localparam int MAGW  = 24;           // magnitude of a difference vector
  localparam int SQW   = 48;           // one squared component
  localparam int D2W   = 49;           // squared distance
  localparam int LSQW  = 46;           // squared limit
  localparam int RADW  = 62;           // square root radicand
  localparam int ROOTW = 31;           // square root result
  localparam int SREMW = 33;           // square root remainder
  localparam int NUMW  = 47;           // normal dividend
  localparam int QW    = 15;           // normal quotient
  localparam int DREMW = 32;           // divider remainder
  localparam int PRW   = QW + HW;      // normal times radius
  localparam int SQ_N  = ROOTW;        // square root steps
  localparam int DV_N  = QW;           // divider steps

  // pair kinds
  localparam logic [KW-1:0] KIND_BB = 2'd0;
  localparam logic [KW-1:0] KIND_BC = 2'd1;
  localparam logic [KW-1:0] KIND_CC = 2'd2;
  localparam logic [KW-1:0] KIND_CB = 2'd3;

  localparam logic [NW-1:0] NORM_ONE = 16'd16384;
  localparam logic [QW-1:0] Q_ONE    = 15'd16384;

  // per-item record carried alongside the square root and divider stages
  typedef struct packed {
    logic            hit;
    logic [KW-1:0]   kind;
    logic            zero;
    logic [NW-1:0]   bnx;
    logic [NW-1:0]   bny;
    logic [PW-1:0]   bpen;
    logic [CW-1:0]   bpx;
    logic [CW-1:0]   bpy;
    logic [HW:0]     lim;
    logic [DW-1:0]   basex;
    logic [DW-1:0]   basey;
    logic [CW-1:0]   zpx;
    logic [CW-1:0]   zpy;
    logic [HW-1:0]   ahx;
    logic [MAGW-1:0] mvx;
    logic [MAGW-1:0] mvy;
    logic            svx;
    logic            svy;
    logic [CW-1:0]   sep;
  } side_t;

  typedef struct packed {
    logic [RADW-1:0]  rad;
    logic [SREMW-1:0] rem;
    logic [ROOTW-1:0] root;
  } sqrt_t;

  typedef struct packed {
    logic [DREMW-1:0] rem;
    logic [QW-1:0]    q;
    logic [QW-1:0]    nlo;
  } div_t;

  // one restoring square root step, two radicand bits in
  function automatic sqrt_t sqrt_step(input sqrt_t c);
    sqrt_t          n;
    logic [SREMW+1:0] t;
    logic [SREMW+1:0] trial;
    t     = {c.rem, c.rad[RADW-1 -: 2]};
    trial = {2'b00, c.root, 2'b01};
    n.rad = {c.rad[RADW-3:0], 2'b00};
    if (t >= trial) begin
      n.rem  = SREMW'(t - trial);
      n.root = {c.root[ROOTW-2:0], 1'b1};
    end else begin
      n.rem  = t[SREMW-1:0];
      n.root = {c.root[ROOTW-2:0], 1'b0};
    end
    return n;
  endfunction

  // one restoring divide step, one quotient bit out
  function automatic div_t div_step(input div_t c, input logic [ROOTW-1:0] s);
    div_t           n;
    logic [DREMW:0] t;
    logic [DREMW:0] sd;
    t     = {c.rem, c.nlo[QW-1]};
    sd    = (DREMW+1)'(s);
    n.nlo = {c.nlo[QW-2:0], 1'b0};
    if (t >= sd) begin
      n.rem = DREMW'(t - sd);
      n.q   = {c.q[QW-2:0], 1'b1};
    end else begin
      n.rem = t[DREMW-1:0];
      n.q   = {c.q[QW-2:0], 1'b0};
    end
    return n;
  endfunction

  // clamp a 26-bit signed value to the signed 24-bit range
  function automatic logic [CW-1:0] sat24(input logic signed [DW:0] v);
    logic [CW-1:0] r;
    if (v > 26'sd8388607) r = 24'h7FFFFF;
    else if (v < -26'sd8388608) r = 24'h800000;
    else r = v[CW-1:0];
    return r;
  endfunction

endpackage

@@ src/aabb_circle_narrow_phase_collision.sv @@
// box/circle narrow-phase collision pipeline, one pair per cycle unless stalled
// depends on aabbc_pkg (widths, kind codes, records, step functions)
//
//   channel | handshake              | payload
//   --------+------------------------+------------------------------------------
//   input   | in_valid / in_stall    | kind, a_/b_ centers and halves, layer data
//   output  | out_valid / out_stall  | hit, normal_x/y, penetration, point_x/y
//
// a new pair is taken every cycle unless the pipeline is stalled. the pipeline
// is the 31-step square root and the 15-step normal divider, one step per
// stage, plus eight stages of setup, squares and output
// rst (synchronous, active high) clears every valid bit; payload is not reset
// the whole pipeline holds while the output register is full and stalled,
// so in_stall follows out_valid and out_stall and nothing is dropped
module aabb_circle_narrow_phase_collision (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [aabbc_pkg::KW-1:0]      kind,
  input  logic signed [aabbc_pkg::CW-1:0] a_center_x,
  input  logic signed [aabbc_pkg::CW-1:0] a_center_y,
  input  logic [aabbc_pkg::HW-1:0]      a_half_x,
  input  logic [aabbc_pkg::HW-1:0]      a_half_y,
  input  logic signed [aabbc_pkg::CW-1:0] b_center_x,
  input  logic signed [aabbc_pkg::CW-1:0] b_center_y,
  input  logic [aabbc_pkg::HW-1:0]      b_half_x,
  input  logic [aabbc_pkg::HW-1:0]      b_half_y,
  input  logic [aabbc_pkg::MW-1:0]      a_layer_mask,
  input  logic [aabbc_pkg::LW-1:0]      b_layer,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          hit,
  output logic signed [aabbc_pkg::NW-1:0] normal_x,
  output logic signed [aabbc_pkg::NW-1:0] normal_y,
  output logic [aabbc_pkg::PW-1:0]      penetration,
  output logic signed [aabbc_pkg::CW-1:0] point_x,
  output logic signed [aabbc_pkg::CW-1:0] point_y
);
  import aabbc_pkg::*;

  // pipeline advances unless a finished result is waiting
  logic adv;
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // ---------------------------------------------------------------- stage 1
  // layer filter, center differences, box bounds and circle selection
  logic                 v1, pass1, cb_sel;
  logic [KW-1:0]        kind1;
  logic signed [DW-1:0] dx1, dy1, lx1, ux1, ly1, uy1;
  logic [HW:0]          mx1, my1;
  logic signed [CW-1:0] cx1, cy1, ax1, ay1;
  logic [HW-1:0]        rad1, ahx1, ahy1;
  logic signed [DW-1:0] axe, aye, bxe, bye, ahxe, ahye, bhxe, bhye;
  logic signed [DW-1:0] boxx, boxy, boxhx, boxhy;

  always_comb begin
    axe   = DW'(a_center_x);
    aye   = DW'(a_center_y);
    bxe   = DW'(b_center_x);
    bye   = DW'(b_center_y);
    ahxe  = $signed(DW'(a_half_x));
    ahye  = $signed(DW'(a_half_y));
    bhxe  = $signed(DW'(b_half_x));
    bhye  = $signed(DW'(b_half_y));
    // circle-box runs as box-circle with the roles swapped
    cb_sel = (kind == KIND_CB);
    boxx  = cb_sel ? bxe : axe;
    boxy  = cb_sel ? bye : aye;
    boxhx = cb_sel ? bhxe : ahxe;
    boxhy = cb_sel ? bhye : ahye;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pass1 <= a_layer_mask[b_layer];
      kind1 <= kind;
      dx1   <= bxe - axe;
      dy1   <= bye - aye;
      mx1   <= (HW+1)'(a_half_x) + (HW+1)'(b_half_x);
      my1   <= (HW+1)'(a_half_y) + (HW+1)'(b_half_y);
      lx1   <= boxx - boxhx;
      ux1   <= boxx + boxhx;
      ly1   <= boxy - boxhy;
      uy1   <= boxy + boxhy;
      cx1   <= cb_sel ? a_center_x : b_center_x;
      cy1   <= cb_sel ? a_center_y : b_center_y;
      rad1  <= cb_sel ? a_half_x : b_half_x;
      ax1   <= a_center_x;
      ay1   <= a_center_y;
      ahx1  <= a_half_x;
      ahy1  <= a_half_y;
    end
    if (rst) v1 <= 1'b0;
    else if (adv) v1 <= in_valid;
  end

  // ---------------------------------------------------------------- stage 2
  // clamp the circle center to the box, form the separation vector
  logic                 v2, pass2, dxp2, dyp2;
  logic [KW-1:0]        kind2;
  logic [MAGW-1:0]      adx2, ady2;
  logic [HW:0]          mx2, my2, lim2;
  logic signed [DW-1:0] vx2, vy2, basex2, basey2;
  logic signed [CW-1:0] zpx2, zpy2, ax2, ay2;
  logic [HW-1:0]        ahx2, ahy2;
  logic signed [DW-1:0] cxe, cye, clx, cly, adxf, adyf;
  logic                 cc1;

  always_comb begin
    cxe  = DW'(cx1);
    cye  = DW'(cy1);
    clx  = (cxe < lx1) ? lx1 : ((cxe > ux1) ? ux1 : cxe);
    cly  = (cye < ly1) ? ly1 : ((cye > uy1) ? uy1 : cye);
    adxf = dx1[DW-1] ? -dx1 : dx1;
    adyf = dy1[DW-1] ? -dy1 : dy1;
    cc1  = (kind1 == KIND_CC);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pass2  <= pass1;
      kind2  <= kind1;
      adx2   <= adxf[MAGW-1:0];
      ady2   <= adyf[MAGW-1:0];
      dxp2   <= !dx1[DW-1] && (dx1 != '0);
      dyp2   <= !dy1[DW-1] && (dy1 != '0);
      mx2    <= mx1;
      my2    <= my1;
      vx2    <= cc1 ? dx1 : cxe - clx;
      vy2    <= cc1 ? dy1 : cye - cly;
      basex2 <= cc1 ? DW'(ax1) : clx;
      basey2 <= cc1 ? DW'(ay1) : cly;
      zpx2   <= cc1 ? ax1 : cx1;
      zpy2   <= cc1 ? ay1 : cy1;
      lim2   <= cc1 ? mx1 : (HW+1)'(rad1);
      ax2    <= ax1;
      ay2    <= ay1;
      ahx2   <= ahx1;
      ahy2   <= ahy1;
    end
    if (rst) v2 <= 1'b0;
    else if (adv) v2 <= v1;
  end

  // ---------------------------------------------------------------- stage 3
  // squares of the vector and the limit, box-box overlap test
  logic                 v3, pass3, dxp3, dyp3, bbhit3, svx3, svy3;
  logic [KW-1:0]        kind3;
  logic [SQW-1:0]       sqx3, sqy3;
  logic [LSQW-1:0]      lsq3;
  logic [MAGW-1:0]      mvx3, mvy3;
  logic [HW:0]          xo3, yo3, lim3;
  logic signed [DW-1:0] basex3, basey3;
  logic signed [CW-1:0] zpx3, zpy3, ax3, ay3;
  logic [HW-1:0]        ahx3, ahy3;
  logic signed [2*DW-1:0] psx, psy;
  logic signed [DW-1:0] avx, avy;

  always_comb begin
    psx = vx2 * vx2;
    psy = vy2 * vy2;
    avx = vx2[DW-1] ? -vx2 : vx2;
    avy = vy2[DW-1] ? -vy2 : vy2;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pass3  <= pass2;
      kind3  <= kind2;
      sqx3   <= psx[SQW-1:0];
      sqy3   <= psy[SQW-1:0];
      lsq3   <= LSQW'(lim2) * LSQW'(lim2);
      mvx3   <= avx[MAGW-1:0];
      mvy3   <= avy[MAGW-1:0];
      svx3   <= vx2[DW-1];
      svy3   <= vy2[DW-1];
      // strict overlap on both axes
      bbhit3 <= (adx2 < MAGW'(mx2)) && (ady2 < MAGW'(my2));
      xo3    <= mx2 - adx2[HW:0];
      yo3    <= my2 - ady2[HW:0];
      dxp3   <= dxp2;
      dyp3   <= dyp2;
      lim3   <= lim2;
      basex3 <= basex2;
      basey3 <= basey2;
      zpx3   <= zpx2;
      zpy3   <= zpy2;
      ax3    <= ax2;
      ay3    <= ay2;
      ahx3   <= ahx2;
      ahy3   <= ahy2;
    end
    if (rst) v3 <= 1'b0;
    else if (adv) v3 <= v2;
  end

  // ---------------------------------------------------------------- stage 4
  // squared distance, box-box result along the smaller overlap
  logic                 v4, pass4, bbhit4, svx4, svy4;
  logic [KW-1:0]        kind4;
  logic [D2W-1:0]       d2_4;
  logic [LSQW-1:0]      lsq4;
  logic [MAGW-1:0]      mvx4, mvy4;
  logic [HW:0]          lim4;
  logic signed [DW-1:0] basex4, basey4;
  logic signed [CW-1:0] zpx4, zpy4;
  logic [HW-1:0]        ahx4;
  logic [NW-1:0]        bnx4, bny4;
  logic [PW-1:0]        bpen4;
  logic [CW-1:0]        bpx4, bpy4;
  logic                 resx;
  logic signed [DW:0]   bax, bay, bhx, bhy, edgex, edgey;

  always_comb begin
    // ties resolve along y
    resx  = (xo3 < yo3);
    bax   = (DW+1)'(ax3);
    bay   = (DW+1)'(ay3);
    bhx   = $signed((DW+1)'(ahx3));
    bhy   = $signed((DW+1)'(ahy3));
    edgex = dxp3 ? bax + bhx : bax - bhx;
    edgey = dyp3 ? bay + bhy : bay - bhy;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pass4  <= pass3;
      kind4  <= kind3;
      bbhit4 <= bbhit3;
      d2_4   <= D2W'(sqx3) + D2W'(sqy3);
      lsq4   <= lsq3;
      mvx4   <= mvx3;
      mvy4   <= mvy3;
      svx4   <= svx3;
      svy4   <= svy3;
      lim4   <= lim3;
      basex4 <= basex3;
      basey4 <= basey3;
      zpx4   <= zpx3;
      zpy4   <= zpy3;
      ahx4   <= ahx3;
      bnx4   <= resx ? (dxp3 ? -NORM_ONE : NORM_ONE) : '0;
      bny4   <= resx ? '0 : (dyp3 ? -NORM_ONE : NORM_ONE);
      bpen4  <= resx ? xo3 : yo3;
      bpx4   <= resx ? sat24(edgex) : ax3;
      bpy4   <= resx ? ay3 : sat24(edgey);
    end
    if (rst) v4 <= 1'b0;
    else if (adv) v4 <= v3;
  end

  // ---------------------------------------------------------------- stage 5
  // contact decision and square root setup; radicand is d2 * 2^16
  side_t  sq_side [0:SQ_N];
  sqrt_t  sq      [0:SQ_N];
  logic   sq_vld  [0:SQ_N];
  side_t  side5;
  logic   hitc;

  always_comb begin
    // a contact at exactly the limit still counts
    hitc          = (d2_4 <= D2W'(lsq4));
    side5.hit     = pass4 && ((kind4 == KIND_BB) ? bbhit4 : hitc);
    side5.kind    = kind4;
    side5.zero    = (d2_4 == '0);
    side5.bnx     = bnx4;
    side5.bny     = bny4;
    side5.bpen    = bpen4;
    side5.bpx     = bpx4;
    side5.bpy     = bpy4;
    side5.lim     = lim4;
    side5.basex   = basex4;
    side5.basey   = basey4;
    side5.zpx     = zpx4;
    side5.zpy     = zpy4;
    side5.ahx     = ahx4;
    side5.mvx     = mvx4;
    side5.mvy     = mvy4;
    side5.svx     = svx4;
    side5.svy     = svy4;
    side5.sep     = '0;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_side[0]   <= side5;
      sq[0].rad    <= {d2_4[LSQW-1:0], 16'h0000};
      sq[0].rem    <= '0;
      sq[0].root   <= '0;
    end
    if (rst) sq_vld[0] <= 1'b0;
    else if (adv) sq_vld[0] <= v4;
  end

  // square root, one result bit per stage
  for (genvar k = 0; k < SQ_N; k++) begin : g_sqrt
    always_ff @(posedge clk) begin
      if (adv) begin
        sq[k+1]      <= sqrt_step(sq[k]);
        sq_side[k+1] <= sq_side[k];
      end
      if (rst) sq_vld[k+1] <= 1'b0;
      else if (adv) sq_vld[k+1] <= sq_vld[k];
    end
  end

  // ---------------------------------------------------------------- divider setup
  // dividend is |d| * 2^22 + s/2 so the quotient rounds half up
  side_t            dv_side [0:DV_N];
  div_t             dvx     [0:DV_N];
  div_t             dvy     [0:DV_N];
  logic [ROOTW-1:0] dv_s    [0:DV_N];
  logic             dv_vld  [0:DV_N];
  logic [ROOTW-1:0] s_root;
  logic [NUMW-1:0]  numx, numy;
  logic [ROOTW:0]   s_rnd;
  side_t            side_d;

  always_comb begin
    s_root      = sq[SQ_N].root;
    numx        = {1'b0, sq_side[SQ_N].mvx, 22'h0} + NUMW'(s_root >> 1);
    numy        = {1'b0, sq_side[SQ_N].mvy, 22'h0} + NUMW'(s_root >> 1);
    s_rnd       = (ROOTW+1)'(s_root) + (ROOTW+1)'(128);
    side_d      = sq_side[SQ_N];
    side_d.sep  = s_rnd[ROOTW:8];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_side[0] <= side_d;
      dv_s[0]    <= s_root;
      dvx[0].rem <= numx[NUMW-1:QW];
      dvx[0].q   <= '0;
      dvx[0].nlo <= numx[QW-1:0];
      dvy[0].rem <= numy[NUMW-1:QW];
      dvy[0].q   <= '0;
      dvy[0].nlo <= numy[QW-1:0];
    end
    if (rst) dv_vld[0] <= 1'b0;
    else if (adv) dv_vld[0] <= sq_vld[SQ_N];
  end

  // two dividers side by side, one quotient bit per stage
  for (genvar j = 0; j < DV_N; j++) begin : g_div
    always_ff @(posedge clk) begin
      if (adv) begin
        dvx[j+1]     <= div_step(dvx[j], dv_s[j]);
        dvy[j+1]     <= div_step(dvy[j], dv_s[j]);
        dv_s[j+1]    <= dv_s[j];
        dv_side[j+1] <= dv_side[j];
      end
      if (rst) dv_vld[j+1] <= 1'b0;
      else if (adv) dv_vld[j+1] <= dv_vld[j];
    end
  end

  // ---------------------------------------------------------------- normal stage
  // clamp, sign, scale by radius for the circle-circle point, penetration
  logic               vm;
  side_t              side_m;
  logic [NW-1:0]      nxm, nym;
  logic [PRW-1:0]     prxm, prym;
  logic [PW-1:0]      penm;
  logic [QW-1:0]      nmx, nmy;
  logic               negx, negy;
  logic signed [DW-1:0] penc;

  always_comb begin
    nmx  = (dvx[DV_N].q > Q_ONE) ? Q_ONE : dvx[DV_N].q;
    nmy  = (dvy[DV_N].q > Q_ONE) ? Q_ONE : dvy[DV_N].q;
    // circle-box flips the normal
    negx = dv_side[DV_N].svx ^ (dv_side[DV_N].kind == KIND_CB);
    negy = dv_side[DV_N].svy ^ (dv_side[DV_N].kind == KIND_CB);
    penc = $signed(DW'(dv_side[DV_N].lim)) - $signed(DW'(dv_side[DV_N].sep));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_m <= dv_side[DV_N];
      nxm    <= negx ? -{1'b0, nmx} : {1'b0, nmx};
      nym    <= negy ? -{1'b0, nmy} : {1'b0, nmy};
      prxm   <= PRW'(nmx) * PRW'(dv_side[DV_N].ahx);
      prym   <= PRW'(nmy) * PRW'(dv_side[DV_N].ahx);
      penm   <= penc[DW-1] ? '0 : penc[PW-1:0];
    end
    if (rst) vm <= 1'b0;
    else if (adv) vm <= dv_vld[DV_N];
  end

  // ---------------------------------------------------------------- output register
  logic [PRW:0]       rndx, rndy;
  logic signed [DW:0] offx, offy, bxw, byw, ptx, pty;

  always_comb begin
    rndx = (PRW+1)'(prxm) + (PRW+1)'(8192);
    rndy = (PRW+1)'(prym) + (PRW+1)'(8192);
    offx = $signed((DW+1)'(rndx[PRW:14]));
    offy = $signed((DW+1)'(rndy[PRW:14]));
    bxw  = (DW+1)'($signed(side_m.basex));
    byw  = (DW+1)'($signed(side_m.basey));
    // circle-circle steps from A's center along the normal by A's radius
    if (side_m.kind == KIND_CC) begin
      ptx = side_m.svx ? bxw - offx : bxw + offx;
      pty = side_m.svy ? byw - offy : byw + offy;
    end else begin
      ptx = bxw;
      pty = byw;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (!side_m.hit) begin
        hit         <= 1'b0;
        normal_x    <= '0;
        normal_y    <= '0;
        penetration <= '0;
        point_x     <= '0;
        point_y     <= '0;
      end else if (side_m.kind == KIND_BB) begin
        hit         <= 1'b1;
        normal_x    <= side_m.bnx;
        normal_y    <= side_m.bny;
        penetration <= side_m.bpen;
        point_x     <= side_m.bpx;
        point_y     <= side_m.bpy;
      end else if (side_m.zero) begin
        // coincident centers or circle center on the box: fixed normal, full limit as depth
        hit         <= 1'b1;
        normal_x    <= (side_m.kind == KIND_CB) ? -NORM_ONE : NORM_ONE;
        normal_y    <= '0;
        penetration <= side_m.lim;
        point_x     <= side_m.zpx;
        point_y     <= side_m.zpy;
      end else begin
        hit         <= 1'b1;
        normal_x    <= nxm;
        normal_y    <= nym;
        penetration <= penm;
        point_x     <= sat24(ptx);
        point_y     <= sat24(pty);
      end
    end
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= vm;
  end

  // ---------------------------------------------------------------- checks
  a_miss_zero : assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> normal_x == '0 && normal_y == '0 && penetration == '0 &&
                          point_x == '0 && point_y == '0)
    else $error("miss with nonzero result fields");

  a_norm_range : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> normal_x <= 16'sd16384 && normal_x >= -16'sd16384 &&
                  normal_y <= 16'sd16384 && normal_y >= -16'sd16384)
    else $error("normal component out of unit range");

  a_hold : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(point_x) && $stable(hit))
    else $error("stalled result changed");

endmodule

@@ tb/tb_top.sv @@
// self-checking bench for the box/circle narrow-phase collision pipeline
// directed table of pairs, then random bursts, checked against typed-in contacts or an in-bench predictor
// depends on aabbc_pkg and aabb_circle_narrow_phase_collision
module tb_top;
  import aabbc_pkg::*;

  // one shape pair as driven on the input ports
  typedef struct {
    logic [KW-1:0]        kind;
    logic signed [CW-1:0] ax, ay, bx, by;
    logic [HW-1:0]        ahx, ahy, bhx, bhy;
    logic [MW-1:0]        mask;
    logic [LW-1:0]        layer;
  } pair_t;

  // one collision result as seen on the output ports
  typedef struct {
    logic                 hit;
    logic signed [NW-1:0] nx, ny;
    logic [PW-1:0]        pen;
    logic signed [CW-1:0] px, py;
  } contact_t;

  // directed row: expected contact typed in only where it is obvious
  typedef struct {
    pair_t    p;
    bit       known;
    contact_t c;
  } row_t;

  localparam longint ONE = 16384;
  localparam int HMAX = 4194303;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [KW-1:0] kind = '0;
  logic signed [CW-1:0] a_center_x = '0, a_center_y = '0, b_center_x = '0, b_center_y = '0;
  logic [HW-1:0] a_half_x = '0, a_half_y = '0, b_half_x = '0, b_half_y = '0;
  logic [MW-1:0] a_layer_mask = '0;
  logic [LW-1:0] b_layer = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic hit;
  logic signed [NW-1:0] normal_x, normal_y;
  logic [PW-1:0] penetration;
  logic signed [CW-1:0] point_x, point_y;

  contact_t expected_contacts[$];
  row_t     rows[$];
  int       errors = 0;
  int       cyc = 0;

  aabb_circle_narrow_phase_collision dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .kind(kind),
    .a_center_x(a_center_x), .a_center_y(a_center_y),
    .a_half_x(a_half_x), .a_half_y(a_half_y),
    .b_center_x(b_center_x), .b_center_y(b_center_y),
    .b_half_x(b_half_x), .b_half_y(b_half_y),
    .a_layer_mask(a_layer_mask), .b_layer(b_layer),
    .out_valid(out_valid), .out_stall(out_stall),
    .hit(hit), .normal_x(normal_x), .normal_y(normal_y),
    .penetration(penetration), .point_x(point_x), .point_y(point_y)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #(20 * 400000);
    $display("tb_top failed");
    $finish;
  end

  // ---------------- predictor ----------------

  function automatic longint mag(input longint v);
    return v < 0 ? -v : v;
  endfunction

  // floor of the square root, bit by bit
  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // one normal component, rounded half up on magnitude and clamped to one
  function automatic longint norm_comp(input longint d, input logic [63:0] s);
    logic [63:0] q;
    q = ((64'(mag(d)) << 22) + s / 2) / s;
    if (q > ONE) q = ONE;
    return d < 0 ? -longint'(q) : longint'(q);
  endfunction

  // unit vector and rounded distance of a nonzero difference
  function automatic void unit_dir(input longint dx, input longint dy,
                                   input logic [63:0] d2, output longint nx,
                                   output longint ny, output longint sep);
    logic [63:0] s;
    s = int_sqrt(d2 << 16);
    nx = norm_comp(dx, s);
    ny = norm_comp(dy, s);
    sep = longint'((s + 128) >> 8);
  endfunction

  // box (bx,by,hx,hy) against circle (cx,cy,rad)
  function automatic void box_vs_circle(input longint bx, input longint by,
                                        input longint hx, input longint hy,
                                        input longint cx, input longint cy,
                                        input longint rad, output bit touch,
                                        output longint nx, output longint ny,
                                        output longint pen, output longint px,
                                        output longint py);
    longint lx, ux, ly, uy, clx, cly, ddx, ddy, sep;
    logic [63:0] d2, r2;
    lx = bx - hx; ux = bx + hx; ly = by - hy; uy = by + hy;
    clx = cx < lx ? lx : (cx > ux ? ux : cx);
    cly = cy < ly ? ly : (cy > uy ? uy : cy);
    ddx = cx - clx;
    ddy = cy - cly;
    d2 = 64'(ddx * ddx) + 64'(ddy * ddy);
    r2 = 64'(rad) * 64'(rad);
    touch = 0; nx = 0; ny = 0; pen = 0; px = 0; py = 0;
    if (d2 <= r2) begin
      touch = 1;
      if (d2 == 0) begin
        // circle center on the box
        nx = ONE; pen = rad; px = cx; py = cy;
      end else begin
        unit_dir(ddx, ddy, d2, nx, ny, sep);
        pen = rad - sep; px = clx; py = cly;
      end
    end
  endfunction

  function automatic logic [CW-1:0] clip24(input longint v);
    if (v > 8388607) return 24'h7FFFFF;
    if (v < -8388608) return 24'h800000;
    return v[CW-1:0];
  endfunction

  function automatic contact_t predict_contact(input pair_t p);
    contact_t c;
    bit touch;
    longint ax, ay, bx, by, ahx, ahy, bhx, bhy;
    longint dx, dy, mx, my, xo, yo, rs, sep, ox, oy;
    longint nx, ny, pen, px, py;
    logic [63:0] d2;
    ax = longint'(p.ax); ay = longint'(p.ay);
    bx = longint'(p.bx); by = longint'(p.by);
    ahx = longint'(p.ahx); ahy = longint'(p.ahy);
    bhx = longint'(p.bhx); bhy = longint'(p.bhy);
    touch = 0; nx = 0; ny = 0; pen = 0; px = 0; py = 0;
    if (p.mask[p.layer]) begin
      case (p.kind)
        KIND_BB: begin
          dx = bx - ax; dy = by - ay;
          mx = ahx + bhx; my = ahy + bhy;
          if (mag(dx) < mx && mag(dy) < my) begin
            touch = 1;
            xo = mx - mag(dx);
            yo = my - mag(dy);
            if (xo < yo) begin
              nx = dx > 0 ? -ONE : ONE; pen = xo;
              px = dx > 0 ? ax + ahx : ax - ahx; py = ay;
            end else begin
              ny = dy > 0 ? -ONE : ONE; pen = yo;
              px = ax; py = dy > 0 ? ay + ahy : ay - ahy;
            end
          end
        end
        KIND_BC: box_vs_circle(ax, ay, ahx, ahy, bx, by, bhx, touch, nx, ny, pen, px, py);
        KIND_CB: begin
          box_vs_circle(bx, by, bhx, bhy, ax, ay, ahx, touch, nx, ny, pen, px, py);
          nx = -nx; ny = -ny;
        end
        default: begin
          dx = bx - ax; dy = by - ay; rs = ahx + bhx;
          d2 = 64'(dx * dx) + 64'(dy * dy);
          if (d2 <= 64'(rs) * 64'(rs)) begin
            touch = 1;
            if (d2 == 0) begin
              nx = ONE; pen = rs; px = ax; py = ay;
            end else begin
              unit_dir(dx, dy, d2, nx, ny, sep);
              pen = rs - sep;
              ox = (mag(nx) * ahx + 8192) >>> 14;
              oy = (mag(ny) * ahx + 8192) >>> 14;
              px = ax + (nx < 0 ? -ox : ox);
              py = ay + (ny < 0 ? -oy : oy);
            end
          end
        end
      endcase
    end
    if (!touch) begin
      nx = 0; ny = 0; pen = 0; px = 0; py = 0;
    end
    if (pen < 0) pen = 0;
    if (pen > 8388607) pen = 8388607;
    c.hit = touch;
    c.nx = nx[NW-1:0];
    c.ny = ny[NW-1:0];
    c.pen = pen[PW-1:0];
    c.px = clip24(px);
    c.py = clip24(py);
    return c;
  endfunction

  // ---------------- stimulus helpers ----------------

  function automatic pair_t make_pair(input logic [KW-1:0] k, input longint ax,
                                      input longint ay, input longint ahx, input longint ahy,
                                      input longint bx, input longint by, input longint bhx,
                                      input longint bhy, input logic [MW-1:0] m,
                                      input logic [LW-1:0] l);
    pair_t p;
    p.kind = k; p.ax = ax[CW-1:0]; p.ay = ay[CW-1:0];
    p.ahx = ahx[HW-1:0]; p.ahy = ahy[HW-1:0];
    p.bx = bx[CW-1:0]; p.by = by[CW-1:0];
    p.bhx = bhx[HW-1:0]; p.bhy = bhy[HW-1:0];
    p.mask = m; p.layer = l;
    return p;
  endfunction

  function automatic contact_t make_contact(input logic h, input longint nx, input longint ny,
                                            input longint pen, input longint px,
                                            input longint py);
    contact_t c;
    c.hit = h; c.nx = nx[NW-1:0]; c.ny = ny[NW-1:0];
    c.pen = pen[PW-1:0]; c.px = px[CW-1:0]; c.py = py[CW-1:0];
    return c;
  endfunction

  task automatic add_row(input pair_t p, input bit known, input contact_t c);
    row_t r;
    r.p = p; r.known = known; r.c = c;
    rows.push_back(r);
  endtask

  // random pair, mostly close enough to touch; a quarter is raw noise
  function automatic pair_t random_pair();
    pair_t p;
    longint span, cx, cy;
    int sz;
    p.kind = KW'($urandom_range(3));
    if ($urandom_range(3) == 0) begin
      p.ax = CW'($urandom); p.ay = CW'($urandom);
      p.bx = CW'($urandom); p.by = CW'($urandom);
      p.ahx = HW'($urandom); p.ahy = HW'($urandom);
      p.bhx = HW'($urandom); p.bhy = HW'($urandom);
      p.mask = $urandom; p.layer = LW'($urandom);
    end else begin
      // mostly small shapes, a few huge ones
      sz = ($urandom_range(9) == 0) ? HMAX : (1 << $urandom_range(16, 4));
      p.ahx = HW'($urandom_range(sz)); p.ahy = HW'($urandom_range(sz));
      p.bhx = HW'($urandom_range(sz)); p.bhy = HW'($urandom_range(sz));
      cx = longint'($signed(CW'($urandom)));
      cy = longint'($signed(CW'($urandom)));
      span = longint'(p.ahx) + longint'(p.bhx) + longint'(p.ahy) + longint'(p.bhy) + 1;
      p.ax = CW'(cx); p.ay = CW'(cy);
      p.bx = CW'(cx + longint'($urandom_range(2 * span)) - span);
      p.by = CW'(cy + longint'($urandom_range(2 * span)) - span);
      // occasionally snap the centers together or onto one axis
      case ($urandom_range(7))
        0: begin p.bx = p.ax; p.by = p.ay; end
        1: p.bx = p.ax;
        2: p.by = p.ay;
        default: ;
      endcase
      p.layer = LW'($urandom);
      p.mask = ($urandom_range(7) == 0) ? $urandom : ($urandom | (32'd1 << p.layer));
    end
    return p;
  endfunction

  task automatic send_pair(input pair_t p);
    in_valid <= 1'b1;
    kind <= p.kind;
    a_center_x <= p.ax; a_center_y <= p.ay;
    a_half_x <= p.ahx; a_half_y <= p.ahy;
    b_center_x <= p.bx; b_center_y <= p.by;
    b_half_x <= p.bhx; b_half_y <= p.bhy;
    a_layer_mask <= p.mask; b_layer <= p.layer;
    do @(posedge clk); while (in_stall);
  endtask

  // ---------------- receiver stall pattern ----------------

  // stall mode steps through none, light and heavy in turn
  always @(posedge clk) begin
    cyc <= cyc + 1;
    case ((cyc >> 6) % 3)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(9) < 3);
      default: out_stall <= ($urandom_range(9) < 7);
    endcase
  end

  // ---------------- result checker ----------------

  always @(posedge clk) begin
    contact_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_contacts.size() == 0) begin
        $error("result with no item outstanding");
        errors++;
      end else begin
        e = expected_contacts.pop_front();
        if (hit !== e.hit) begin
          $error("hit expected %0d got %0d", e.hit, hit); errors++;
        end
        if (normal_x !== e.nx) begin
          $error("normal_x expected %0d got %0d", e.nx, normal_x); errors++;
        end
        if (normal_y !== e.ny) begin
          $error("normal_y expected %0d got %0d", e.ny, normal_y); errors++;
        end
        if (penetration !== e.pen) begin
          $error("penetration expected %0d got %0d", e.pen, penetration); errors++;
        end
        if (point_x !== e.px) begin
          $error("point_x expected %0d got %0d", e.px, point_x); errors++;
        end
        if (point_y !== e.py) begin
          $error("point_y expected %0d got %0d", e.py, point_y); errors++;
        end
      end
    end
  end

  // ---------------- main sequence ----------------

  initial begin
    contact_t none, any;
    int burst, gap, waited;
    pair_t p;
    none = make_contact(0, 0, 0, 0, 0, 0);
    any = none;

    // layer filter blocks an otherwise overlapping pair
    add_row(make_pair(KIND_CC, 0, 0, 100, 0, 0, 0, 100, 0, 32'hFFFF_FFFE, 0), 1, none);
    // layer filter on the top bit
    add_row(make_pair(KIND_CC, 0, 0, 100, 0, 0, 0, 100, 0, 32'h8000_0000, 31), 1,
            make_contact(1, ONE, 0, 200, 0, 0));
    // box-box along x, b to the right
    add_row(make_pair(KIND_BB, 0, 0, 256, 256, 256, 0, 256, 512, 32'h1, 0), 1,
            make_contact(1, -ONE, 0, 256, 256, 0));
    // box-box just touching is not a hit (strict less-than)
    add_row(make_pair(KIND_BB, 0, 0, 256, 256, 512, 0, 256, 256, 32'h1, 0), 1, none);
    // box-box tie in overlap goes to y, zero difference gives +1
    add_row(make_pair(KIND_BB, 0, 0, 100, 100, 0, 0, 100, 100, 32'h1, 0), 1,
            make_contact(1, 0, ONE, 200, 0, -100));
    // box-box along y, b below
    add_row(make_pair(KIND_BB, 10, 10, 500, 50, 10, -40, 500, 50, 32'h4, 2), 0, any);
    // circle-circle coincident centers
    add_row(make_pair(KIND_CC, 0, 0, 100, 7, 0, 0, 200, 9, 32'h1, 0), 1,
            make_contact(1, ONE, 0, 300, 0, 0));
    // circle-circle at exactly the radius sum
    add_row(make_pair(KIND_CC, 0, 0, 300, 0, 500, 0, 200, 0, 32'h1, 0), 1,
            make_contact(1, ONE, 0, 0, 300, 0));
    // circle-circle diagonal
    add_row(make_pair(KIND_CC, -77, 123, 900, 0, 301, -250, 700, 0, 32'h1, 0), 0, any);
    // box-circle with center on the box
    add_row(make_pair(KIND_BC, 0, 0, 100, 100, 10, 20, 50, 0, 32'h1, 0), 1,
            make_contact(1, ONE, 0, 50, 10, 20));
    // box-circle corner
    add_row(make_pair(KIND_BC, 0, 0, 100, 100, 150, 160, 90, 0, 32'h1, 0), 0, any);
    // box-circle at exactly the radius
    add_row(make_pair(KIND_BC, 0, 0, 100, 100, 0, 150, 50, 0, 32'h1, 0), 1,
            make_contact(1, 0, ONE, 0, 0, 100));
    // circle-box with center on the box gives (-1,0)
    add_row(make_pair(KIND_CB, 10, 10, 50, 0, 0, 0, 100, 100, 32'h1, 0), 1,
            make_contact(1, -ONE, 0, 50, 10, 10));
    // circle-box from the left
    add_row(make_pair(KIND_CB, -180, 5, 100, 0, 0, 0, 100, 100, 32'h1, 0), 0, any);
    // circle-box miss
    add_row(make_pair(KIND_CB, -500, 0, 100, 0, 0, 0, 100, 100, 32'h1, 0), 1, none);
    // extremes: point saturates low, largest halves
    add_row(make_pair(KIND_BB, -8388608, -8388608, HMAX, HMAX, -8388608, -8388608,
                      HMAX, HMAX, 32'hFFFF_FFFF, 31), 0, any);
    add_row(make_pair(KIND_BB, 8388607, 8388607, HMAX, 10, 8388607, 8388607,
                      HMAX, 10, 32'hFFFF_FFFF, 17), 0, any);
    add_row(make_pair(KIND_BB, 8388607, 0, 10, HMAX, 8388600, 0, 10, HMAX,
                      32'hFFFF_FFFF, 5), 0, any);
    add_row(make_pair(KIND_CC, 8388607, 8388607, HMAX, HMAX, -8388608, -8388608,
                      HMAX, HMAX, 32'hFFFF_FFFF, 3), 0, any);
    add_row(make_pair(KIND_CC, -8388608, 0, HMAX, 0, -8388608, 0, HMAX, 0,
                      32'hFFFF_FFFF, 3), 0, any);
    add_row(make_pair(KIND_CC, 8388607, 8388607, HMAX, 0, 8388000, 8388100, HMAX, 0,
                      32'hFFFF_FFFF, 3), 0, any);
    add_row(make_pair(KIND_BC, 8388607, -8388608, HMAX, HMAX, -8388608, 8388607, HMAX,
                      HMAX, 32'hFFFF_FFFF, 9), 0, any);
    add_row(make_pair(KIND_CB, 8388607, 8388607, HMAX, HMAX, 8388607, -8388608, HMAX,
                      HMAX, 32'hFFFF_FFFF, 9), 0, any);
    add_row(make_pair(KIND_BC, 0, 0, 0, 0, 0, 0, 0, 0, 32'h1, 0), 1,
            make_contact(1, ONE, 0, 0, 0, 0));

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    foreach (rows[i]) begin
      send_pair(rows[i].p);
      expected_contacts.push_back(rows[i].known ? rows[i].c : predict_contact(rows[i].p));
      if ($urandom_range(3) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(3, 1)) @(posedge clk);
      end
    end

    // random bursts with random gaps, some back to back
    for (int n = 0; n < 400; ) begin
      burst = $urandom_range(24, 1);
      for (int j = 0; j < burst && n < 400; j++, n++) begin
        p = random_pair();
        send_pair(p);
        expected_contacts.push_back(predict_contact(p));
      end
      gap = ($urandom_range(2) == 0) ? 0 : $urandom_range(8, 1);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b0;

    // drain, then allow the pipeline depth for any stray result
    waited = 0;
    while (expected_contacts.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    if (expected_contacts.size() != 0) begin
      $error("%0d results never arrived", expected_contacts.size());
      errors++;
    end
    repeat (80) @(posedge clk);

    if (errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

@@ aabb_circle_narrow_phase_collision.f @@
src/aabbc_pkg.sv
src/aabb_circle_narrow_phase_collision.sv
tb/tb_top.sv
